### design/ibqm_pkg.sv
// ----------------------------------------------------------------------------
// ibqm_pkg
// Shared widths, types and constants for the inverse bilinear quad mapper.
// ----------------------------------------------------------------------------
package ibqm_pkg;

	localparam int CoordW = 32;
	localparam int DiffW  = 31;
	localparam int CrossW = 62;
	localparam int QW     = 18;
	localparam int WideW  = 128;
	localparam int SqW    = 64;
	localparam int NumW   = 66;
	localparam int QuotW  = 24;
	localparam int NRegs  = 8;

	localparam logic signed [DiffW-1:0] DiffLim = 31'sd536870911;
	localparam logic signed [QuotW-1:0] OneQ16  = 24'sd65536;
	localparam logic signed [QuotW-1:0] QuotSat = 24'sd2097152;

	typedef enum logic [2:0] {
		REG_BL_X = 3'd0, REG_BL_Y = 3'd1, REG_BR_X = 3'd2, REG_BR_Y = 3'd3,
		REG_TL_X = 3'd4, REG_TL_Y = 3'd5, REG_TR_X = 3'd6, REG_TR_Y = 3'd7
	} reg_idx_t;

	typedef logic signed [DiffW-1:0] diff_t;
	typedef diff_t diffs_t [8];

	function automatic diff_t sat_diff(input logic signed [CoordW-1:0] p,
		input logic signed [CoordW-1:0] q);
		logic signed [CoordW:0] d;
		d = {p[CoordW-1], p} - {q[CoordW-1], q};
		if (d > 33'sd536870911)       sat_diff = DiffLim;
		else if (d < -33'sd536870911) sat_diff = -DiffLim;
		else                          sat_diff = d[DiffW-1:0];
	endfunction

endpackage

### design/inverse_bilinear_quad_map.sv
// ----------------------------------------------------------------------------
// inverse_bilinear_quad_map
// Throughput one point per cycle while out_valid && out_stall does not hold the pipe.
// The depth is set by the bit-per-stage square root and the two rounds of
// bit-per-stage dividers. A stall freezes every stage together.
// Reset clears valid bits and corner registers; payload stages are not reset.
// ----------------------------------------------------------------------------
module inverse_bilinear_quad_map #(
	parameter int TOLERANCE_LSB = 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  solution_count,
	output logic signed [17:0] first_s,
	output logic signed [17:0] first_t,
	output logic signed [17:0] second_s,
	output logic signed [17:0] second_t
);
	import ibqm_pkg::*;

	localparam int LatA = 62;   // isqrt depth
	localparam int LatD = 22;   // divider depth
	localparam int Depth = 6 + LatA + LatD + 3 + LatD + 2;

	logic signed [CoordW-1:0] corner_q [NRegs];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NRegs; i++) corner_q[i] <= '0;
		end else if (cfg_we) begin
			corner_q[cfg_index] <= cfg_data;
		end
	end

	// whole pipe advances together; output register never overwritten while held
	logic en;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	logic [Depth-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[Depth-2:0], in_valid};
	end
	assign out_valid = vld_q[Depth-1];

	function automatic logic near0(input logic signed [NumW+7:0] v);
		logic [NumW+7:0] m;
		m = v[NumW+7] ? -v : v;
		near0 = (m == 0) || (m < (NumW+8)'(TOLERANCE_LSB));
	endfunction

	function automatic logic in_unit(input logic signed [QuotW-1:0] v);
		in_unit = (32'(v) + TOLERANCE_LSB >= 0) && (32'(v) - TOLERANCE_LSB <= 65536);
	endfunction

	// ---- s1: differences
	diffs_t df_s1;
	always_ff @(posedge clk) if (en) begin
		df_s1[0] <= sat_diff(corner_q[REG_BL_X], corner_q[REG_TL_X]);
		df_s1[1] <= sat_diff(corner_q[REG_BL_Y], corner_q[REG_TL_Y]);
		df_s1[2] <= sat_diff(corner_q[REG_BR_X], corner_q[REG_TR_X]);
		df_s1[3] <= sat_diff(corner_q[REG_BR_Y], corner_q[REG_TR_Y]);
		df_s1[4] <= sat_diff(corner_q[REG_BL_X], point_x);
		df_s1[5] <= sat_diff(corner_q[REG_BL_Y], point_y);
		df_s1[6] <= sat_diff(corner_q[REG_BR_X], point_x);
		df_s1[7] <= sat_diff(corner_q[REG_BR_Y], point_y);
	end

	// ---- s2: products (8 x 31b*31b)
	logic signed [CrossW-1:0] pr_s2 [8];
	diffs_t df_s2;
	always_ff @(posedge clk) if (en) begin
		pr_s2[0] <= df_s1[4] * df_s1[1]; pr_s2[1] <= df_s1[5] * df_s1[0];
		pr_s2[2] <= df_s1[4] * df_s1[3]; pr_s2[3] <= df_s1[5] * df_s1[2];
		pr_s2[4] <= df_s1[6] * df_s1[1]; pr_s2[5] <= df_s1[7] * df_s1[0];
		pr_s2[6] <= df_s1[6] * df_s1[3]; pr_s2[7] <= df_s1[7] * df_s1[2];
		df_s2 <= df_s1;
	end

	// ---- s3: cross products and coefficients
	logic signed [64:0] a_s3, c_s3, bs_s3, q_s3;
	diffs_t df_s3;
	always_ff @(posedge clk) if (en) begin
		logic signed [64:0] a, b1, b2, c;
		a  = 65'(pr_s2[0]) - 65'(pr_s2[1]);
		b1 = 65'(pr_s2[2]) - 65'(pr_s2[3]);
		b2 = 65'(pr_s2[4]) - 65'(pr_s2[5]);
		c  = 65'(pr_s2[6]) - 65'(pr_s2[7]);
		a_s3 <= a; c_s3 <= c; bs_s3 <= b1 + b2; q_s3 <= a - b1 - b2 + c;
		df_s3 <= df_s2;
	end

	// ---- s4: magnitude products for discriminant (split into 32b partials)
	logic [63:0] mb_s4, ma_s4, mc_s4;
	logic signed [64:0] a_s4, c_s4, bs_s4, q_s4;
	diffs_t df_s4;
	always_ff @(posedge clk) if (en) begin
		mb_s4 <= 64'(bs_s3[64] ? -bs_s3 : bs_s3);
		ma_s4 <= 64'(a_s3[64] ? -a_s3 : a_s3);
		mc_s4 <= 64'(c_s3[64] ? -c_s3 : c_s3);
		a_s4 <= a_s3; c_s4 <= c_s3; bs_s4 <= bs_s3; q_s4 <= q_s3; df_s4 <= df_s3;
	end

	logic [63:0] pp_s5 [8];
	logic signed [64:0] a_s5, c_s5, bs_s5, q_s5;
	diffs_t df_s5;
	always_ff @(posedge clk) if (en) begin
		pp_s5[0] <= mb_s4[31:0] * mb_s4[31:0];   pp_s5[1] <= mb_s4[31:0] * mb_s4[63:32];
		pp_s5[2] <= mb_s4[63:32] * mb_s4[63:32]; pp_s5[3] <= ma_s4[31:0] * mc_s4[31:0];
		pp_s5[4] <= ma_s4[31:0] * mc_s4[63:32];  pp_s5[5] <= ma_s4[63:32] * mc_s4[31:0];
		pp_s5[6] <= ma_s4[63:32] * mc_s4[63:32]; pp_s5[7] <= '0;
		a_s5 <= a_s4; c_s5 <= c_s4; bs_s5 <= bs_s4; q_s5 <= q_s4; df_s5 <= df_s4;
	end

	// ---- s6: discriminant and path selection
	logic [WideW-1:0] disc_s6;
	logic lin_s6, bad_s6;
	logic signed [NumW-1:0] n1_s6, d1_s6;  // linear-path numerator/den, or lin/2q
	diffs_t df_s6;
	always_ff @(posedge clk) if (en) begin
		logic [WideW-1:0] bb, ac, ac4;
		logic qz, opp;
		bb  = {64'd0, pp_s5[0]} + ({64'd0, pp_s5[1]} << 33) + ({64'd0, pp_s5[2]} << 64);
		ac  = {64'd0, pp_s5[3]} + ({64'd0, pp_s5[4]} << 32) + ({64'd0, pp_s5[5]} << 32)
			+ ({64'd0, pp_s5[6]} << 64);
		ac4 = ac << 2;
		qz  = near0((NumW+8)'(q_s5));
		opp = (a_s5[64] != c_s5[64]) && a_s5 != 0 && c_s5 != 0;
		lin_s6  <= qz;
		disc_s6 <= opp ? bb + ac4 : bb - ac4;
		if (qz) bad_s6 <= near0((NumW+8)'(a_s5 - c_s5));
		else    bad_s6 <= !opp && (ac4 > bb);
		n1_s6 <= qz ? NumW'(a_s5) : NumW'(2 * a_s5 - bs_s5);
		d1_s6 <= qz ? NumW'(a_s5 - c_s5) : NumW'(2 * q_s5);
		df_s6 <= df_s5;
	end

	// ---- square root with side data
	localparam int SideW = 2 + 2*NumW + 8*DiffW;
	logic [SideW-1:0] side_in, side_out;
	logic [SqW-1:0] sq;
	always_comb begin
		side_in = {lin_s6, bad_s6, n1_s6, d1_s6,
			df_s6[0], df_s6[1], df_s6[2], df_s6[3],
			df_s6[4], df_s6[5], df_s6[6], df_s6[7]};
	end
	ibqm_isqrt #(.TW(SideW)) u_sqrt (
		.clk, .en, .rad(disc_s6), .tag_in(side_in), .root(sq), .tag_out(side_out)
	);

	logic lin_r, bad_r;
	logic signed [NumW-1:0] n1_r, d1_r;
	diffs_t df_r;
	assign {lin_r, bad_r, n1_r, d1_r, df_r[0], df_r[1], df_r[2], df_r[3],
		df_r[4], df_r[5], df_r[6], df_r[7]} = side_out;

	// ---- s dividers
	logic signed [NumW-1:0] na, nb;
	assign na = lin_r ? n1_r : n1_r - NumW'(sq);
	assign nb = lin_r ? n1_r : n1_r + NumW'(sq);
	localparam int ST = 2 + 8*DiffW;
	logic signed [QuotW-1:0] sa, sb;
	logic [ST-1:0] stg_o, stg_dummy;
	ibqm_div #(.TW(ST)) u_sdiv1 (
		.clk, .arst_n, .en, .num(na), .den(d1_r),
		.tag_in({lin_r, bad_r, df_r[0], df_r[1], df_r[2], df_r[3], df_r[4], df_r[5],
			df_r[6], df_r[7]}),
		.quot(sa), .tag_out(stg_o)
	);
	ibqm_div #(.TW(ST)) u_sdiv2 (
		.clk, .arst_n, .en, .num(nb), .den(d1_r), .tag_in('0),
		.quot(sb), .tag_out(stg_dummy)
	);
	logic lin_d, bad_d;
	diffs_t df_d;
	assign {lin_d, bad_d, df_d[0], df_d[1], df_d[2], df_d[3],
		df_d[4], df_d[5], df_d[6], df_d[7]} = stg_o;

	// ---- t1: root selection
	logic [1:0] ns_t1;
	logic signed [QuotW-1:0] s1_t1, s2_t1;
	diffs_t df_t1;
	always_ff @(posedge clk) if (en) begin
		logic u1, u2;
		u1 = in_unit(sa);
		u2 = in_unit(sb);
		s1_t1 <= sa; s2_t1 <= sb;
		if (bad_d)      ns_t1 <= 2'd0;
		else if (lin_d) ns_t1 <= u1 ? 2'd1 : 2'd0;
		else if (u1)    ns_t1 <= u2 ? 2'd2 : 2'd1;
		else if (u2) begin
			ns_t1 <= 2'd1; s1_t1 <= sb;
		end else        ns_t1 <= 2'd0;
		df_t1 <= df_d;
	end

	// ---- t2: products for t denominators/numerators (s fits 18b signed)
	logic signed [NumW-1:0] px_t2 [2][8];
	logic [1:0] ns_t2;
	logic signed [QuotW-1:0] s1_t2, s2_t2;
	always_ff @(posedge clk) if (en) begin
		for (int r = 0; r < 2; r++) begin
			logic signed [QuotW-1:0] s, o;
			s = r == 0 ? s1_t1 : s2_t1;
			o = OneQ16 - s;
			// (1-s) pairs with BL-side diffs, s with BR-side diffs
			for (int k = 0; k < 4; k++) begin
				px_t2[r][2*k]   <= NumW'(o) * NumW'(df_t1[(k < 2) ? k : k + 2]);
				px_t2[r][2*k+1] <= NumW'(s) * NumW'(df_t1[(k < 2) ? k + 2 : k + 4]);
			end
		end
		ns_t2 <= ns_t1; s1_t2 <= s1_t1; s2_t2 <= s2_t1;
	end

	// ---- t3: choose denominator
	logic signed [NumW-1:0] tn_t3 [2], td_t3 [2];
	logic ok_t3 [2];
	logic [1:0] ns_t3;
	logic signed [QuotW-1:0] s1_t3, s2_t3;
	always_ff @(posedge clk) if (en) begin
		for (int r = 0; r < 2; r++) begin
			logic signed [NumW-1:0] dx, dy, nx, ny, mx, my;
			dx = px_t2[r][0] + px_t2[r][1];
			dy = px_t2[r][2] + px_t2[r][3];
			nx = px_t2[r][4] + px_t2[r][5];
			ny = px_t2[r][6] + px_t2[r][7];
			mx = dx[NumW-1] ? -dx : dx;
			my = dy[NumW-1] ? -dy : dy;
			ok_t3[r] <= !(near0((NumW+8)'(dx)) && near0((NumW+8)'(dy)));
			tn_t3[r] <= (mx > my) ? nx : ny;
			td_t3[r] <= (mx > my) ? dx : dy;
			if (near0((NumW+8)'(dx)) && near0((NumW+8)'(dy))) td_t3[r] <= NumW'(1);
		end
		ns_t3 <= ns_t2; s1_t3 <= s1_t2; s2_t3 <= s2_t2;
	end

	localparam int TT = 4 + 2*QuotW;
	logic signed [QuotW-1:0] ta, tb;
	logic [TT-1:0] ttg_o, ttg_dummy;
	ibqm_div #(.TW(TT)) u_tdiv1 (
		.clk, .arst_n, .en, .num(tn_t3[0]), .den(td_t3[0]),
		.tag_in({ns_t3, ok_t3[0], ok_t3[1], s1_t3, s2_t3}), .quot(ta), .tag_out(ttg_o)
	);
	ibqm_div #(.TW(TT)) u_tdiv2 (
		.clk, .arst_n, .en, .num(tn_t3[1]), .den(td_t3[1]), .tag_in('0),
		.quot(tb), .tag_out(ttg_dummy)
	);
	logic [1:0] ns_e;
	logic ok1_e, ok2_e;
	logic signed [QuotW-1:0] s1_e, s2_e;
	assign {ns_e, ok1_e, ok2_e, s1_e, s2_e} = ttg_o;

	// ---- output stage (t4 then register)
	logic [1:0] cnt_o;
	logic signed [QW-1:0] fs_o, ft_o, ss_o, st_o;
	logic [1:0] cnt_q;
	logic signed [QW-1:0] fs_q, ft_q, ss_q, st_q;
	always_ff @(posedge clk) if (en) begin
		logic v1, v2;
		v1 = ns_e != 2'd0 && ok1_e && in_unit(ta);
		v2 = ns_e == 2'd2 && ok2_e && in_unit(tb);
		cnt_q <= {1'b0, v1} + {1'b0, v2};
		fs_q <= '0; ft_q <= '0; ss_q <= '0; st_q <= '0;
		if (v1) begin
			fs_q <= s1_e[QW-1:0]; ft_q <= ta[QW-1:0];
			if (v2) begin
				ss_q <= s2_e[QW-1:0]; st_q <= tb[QW-1:0];
			end
		end else if (v2) begin
			fs_q <= s2_e[QW-1:0]; ft_q <= tb[QW-1:0];
		end
	end
	always_ff @(posedge clk) if (en) begin
		cnt_o <= cnt_q; fs_o <= fs_q; ft_o <= ft_q; ss_o <= ss_q; st_o <= st_q;
	end
	assign solution_count = cnt_o;
	assign first_s = fs_o; assign first_t = ft_o;
	assign second_s = ss_o; assign second_t = st_o;

	logic unused;
	assign unused = ^{stg_dummy, ttg_dummy};

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> solution_count != 2'd3) else $error("bad count");
	a_zero_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && solution_count == 2'd0 |-> first_s == 0 && first_t == 0)
		else $error("fields not cleared");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(first_s))
		else $error("result lost under stall");
endmodule

### design/ibqm_div.sv
// ----------------------------------------------------------------------------
// ibqm_div
// Pipelined rounded Q.16 divider: one quotient bit per stage, with saturation
// at magnitude 32.
// ----------------------------------------------------------------------------
module ibqm_div #(
	parameter int TW = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic signed [ibqm_pkg::NumW-1:0] num,
	input  logic signed [ibqm_pkg::NumW-1:0] den,
	input  logic [TW-1:0]               tag_in,
	output logic signed [ibqm_pkg::QuotW-1:0] quot,
	output logic [TW-1:0]               tag_out
);
	import ibqm_pkg::*;

	// 22 restoring steps: 5 integer bits (sat test) + 17 fraction bits
	localparam int Steps = 22;
	localparam int MW = NumW;

	logic [MW-1:0]  rem_s [Steps+1];
	logic [MW-1:0]  den_s [Steps+1];
	logic [Steps-1:0] qb_s [Steps+1];
	logic           neg_s [Steps+1];
	logic           sat_s [Steps+1];
	logic [TW-1:0]  tag_s [Steps+1];

	logic [MW-1:0] un, ud;
	assign un = num[MW-1] ? MW'(-num) : MW'(num);
	assign ud = den[MW-1] ? MW'(-den) : MW'(den);

	always_comb begin
		rem_s[0] = un;
		den_s[0] = ud;
		qb_s[0]  = '0;
		neg_s[0] = num[MW-1] != den[MW-1];
		// integer part >= 32 detected up front: un >= 32*ud
		sat_s[0] = {5'd0, un} >= {ud, 5'd0};
		tag_s[0] = tag_in;
	end

	for (genvar i = 0; i < Steps; i++) begin : g_step
		localparam int Sh = 4 - i;
		logic [MW+5:0] r_w, d_w;
		logic          take;
		always_comb begin
			r_w = {6'd0, rem_s[i]};
			if (Sh >= 0) d_w = {6'd0, den_s[i]} << (Sh >= 0 ? Sh : 0);
			else         d_w = {6'd0, den_s[i]};
			if (Sh < 0)  r_w = r_w << 1;
			take = r_w >= d_w;
		end
		logic [MW+5:0] r_n;
		assign r_n = take ? r_w - d_w : r_w;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= r_n[MW-1:0];
				den_s[i+1] <= den_s[i];
				qb_s[i+1]  <= {qb_s[i][Steps-2:0], take};
				neg_s[i+1] <= neg_s[i];
				sat_s[i+1] <= sat_s[i];
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	logic [QuotW-1:0] mq;
	always_comb begin
		// qb = int(5) frac(17); q = (int<<16) + (frac+1)>>1
		mq = {qb_s[Steps][21:17], 16'd0} + QuotW'(({1'b0, qb_s[Steps][16:0]} + 18'd1) >> 1);
		if (sat_s[Steps]) mq = QuotSat;
	end
	assign quot    = neg_s[Steps] ? -$signed(mq) : $signed(mq);
	assign tag_out = tag_s[Steps];

	logic unused_rst;
	assign unused_rst = arst_n;
endmodule

### design/ibqm_isqrt.sv
// ----------------------------------------------------------------------------
// ibqm_isqrt
// Pipelined floor square root of the low 124 bits of a 128-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module ibqm_isqrt #(
	parameter int TW = 8
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [ibqm_pkg::WideW-1:0]   rad,
	input  logic [TW-1:0]                tag_in,
	output logic [ibqm_pkg::SqW-1:0]     root,
	output logic [TW-1:0]                tag_out
);
	import ibqm_pkg::*;

	localparam int Steps = 62;

	// non-restoring-free digit recurrence: rem, root built MSB first
	logic [WideW-1:0] rad_s [Steps+1];
	logic [WideW+1:0] rem_s [Steps+1];
	logic [SqW-1:0]   rt_s  [Steps+1];
	logic [TW-1:0]    tag_s [Steps+1];

	assign rad_s[0] = rad;
	assign rem_s[0] = '0;
	assign rt_s[0]  = '0;
	assign tag_s[0] = tag_in;

	for (genvar i = 0; i < Steps; i++) begin : g_step
		localparam int B = Steps - 1 - i;
		logic [WideW+1:0] r_sh, trial;
		logic take;
		always_comb begin
			r_sh  = {rem_s[i][WideW-1:0], rad_s[i][2*B+1 -: 2]};
			trial = {rt_s[i][SqW-1:0], 2'b01};
			take  = r_sh >= trial;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i+1] <= rad_s[i];
				rem_s[i+1] <= take ? r_sh - trial : r_sh;
				rt_s[i+1]  <= {rt_s[i][SqW-2:0], take};
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	assign root    = rt_s[Steps];
	assign tag_out = tag_s[Steps];
endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for inverse_bilinear_quad_map: streams query points over
// several corner settings and compares each (s,t) result with a local solver.
// ----------------------------------------------------------------------------
module tb;
	import ibqm_pkg::*;

	typedef struct {
		logic [1:0]        cnt;
		logic signed [17:0] s1, t1, s2, t2;
	} st_pair_t;

	typedef struct {
		int        ph;
		bit [31:0] x, y;
		bit        zero_known;
	} point_row_t;

	localparam longint ONE = 65536;
	localparam longint TOL = 1;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic signed [31:0] point_x, point_y;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] solution_count;
	logic signed [17:0] first_s, first_t, second_s, second_t;

	st_pair_t  pending_st[$];
	point_row_t rows[$];
	longint    corner_q8[8];
	longint    dd[8];
	int        errors = 0;
	bit        calm = 1'b0;
	int        stall_left = 0;

	inverse_bilinear_quad_map dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("tb NOT OK");
		$finish;
	end

	function automatic longint clip_diff(longint p, longint q);
		longint d;
		d = p - q;
		if (d > 536870911) return 536870911;
		if (d < -536870911) return -536870911;
		return d;
	endfunction

	function automatic longint unsigned absv(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic bit in_unit(longint v);
		return (v + TOL >= 0) && (v - TOL <= ONE);
	endfunction

	function automatic bit near_zero(longint v);
		return (v == 0) || (absv(v) < TOL);
	endfunction

	// round(n * 2^16 / d), halves away from zero, saturated
	function automatic longint quot16(longint n, longint d);
		bit neg;
		longint unsigned un, ud, q0, r, fr, q;
		neg = (n < 0) != (d < 0);
		un = absv(n);
		ud = absv(d);
		q0 = un / ud;
		r = un % ud;
		fr = 0;
		if (q0 >= 32) q = 2097152;
		else begin
			for (int i = 0; i < 17; i++) begin
				r = r << 1;
				fr = fr << 1;
				if (r >= ud) begin
					r = r - ud;
					fr = fr | 1;
				end
			end
			q = (q0 << 16) + ((fr + 1) >> 1);
		end
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint unsigned floor_root(logic [127:0] d);
		longint unsigned res, c;
		logic [127:0] cc;
		res = 0;
		for (int i = 61; i >= 0; i--) begin
			c = res | (64'd1 << i);
			cc = {64'd0, c} * {64'd0, c};
			if (cc <= d) res = c;
		end
		return res;
	endfunction

	function automatic bit t_for_s(longint s, output longint t);
		longint oms, dx, dy, num, den;
		oms = ONE - s;
		dx = oms * dd[0] + s * dd[2];
		dy = oms * dd[1] + s * dd[3];
		t = 0;
		if (near_zero(dx) && near_zero(dy)) return 1'b0;
		if (absv(dx) > absv(dy)) begin
			num = oms * dd[4] + s * dd[6];
			den = dx;
		end else begin
			num = oms * dd[5] + s * dd[7];
			den = dy;
		end
		t = quot16(num, den);
		return in_unit(t);
	endfunction

	function automatic st_pair_t solve_point(logic signed [31:0] px, logic signed [31:0] py);
		st_pair_t r;
		longint a, b1, b2, c, bs, qc, lin, s1, s2, t1, t2;
		longint unsigned sq;
		logic [127:0] bb, ac, disc;
		int ns;
		bit v1, v2;
		r = '{default: '0};
		s1 = 0; s2 = 0; t1 = 0; t2 = 0; ns = 0; v1 = 0; v2 = 0;
		dd[0] = clip_diff(corner_q8[REG_BL_X], corner_q8[REG_TL_X]);
		dd[1] = clip_diff(corner_q8[REG_BL_Y], corner_q8[REG_TL_Y]);
		dd[2] = clip_diff(corner_q8[REG_BR_X], corner_q8[REG_TR_X]);
		dd[3] = clip_diff(corner_q8[REG_BR_Y], corner_q8[REG_TR_Y]);
		dd[4] = clip_diff(corner_q8[REG_BL_X], px);
		dd[5] = clip_diff(corner_q8[REG_BL_Y], py);
		dd[6] = clip_diff(corner_q8[REG_BR_X], px);
		dd[7] = clip_diff(corner_q8[REG_BR_Y], py);
		a  = dd[4] * dd[1] - dd[5] * dd[0];
		b1 = dd[4] * dd[3] - dd[5] * dd[2];
		b2 = dd[6] * dd[1] - dd[7] * dd[0];
		c  = dd[6] * dd[3] - dd[7] * dd[2];
		bs = b1 + b2;
		qc = a - bs + c;
		if (near_zero(qc)) begin
			// linear case
			if (near_zero(a - c)) return r;
			s1 = quot16(a, a - c);
			if (in_unit(s1)) ns = 1;
		end else begin
			bb = {64'd0, absv(bs)} * {64'd0, absv(bs)};
			ac = ({64'd0, absv(a)} * {64'd0, absv(c)}) << 2;
			lin = 2 * a - bs;
			if ((a < 0) != (c < 0) && a != 0 && c != 0) disc = bb + ac;
			else begin
				if (ac > bb) return r;
				disc = bb - ac;
			end
			sq = floor_root(disc);
			s1 = quot16(lin - longint'(sq), 2 * qc);
			s2 = quot16(lin + longint'(sq), 2 * qc);
			if (in_unit(s1)) ns = in_unit(s2) ? 2 : 1;
			else if (in_unit(s2)) begin
				ns = 1;
				s1 = s2;
			end
		end
		if (ns == 0) return r;
		v1 = t_for_s(s1, t1);
		if (ns == 2) v2 = t_for_s(s2, t2);
		if (v2 && !v1) begin
			s1 = s2; t1 = t2; v1 = 1; v2 = 0;
		end
		r.cnt = 2'(int'(v1) + int'(v2));
		if (v1) begin
			r.s1 = s1[17:0];
			r.t1 = t1[17:0];
		end
		if (v2) begin
			r.s2 = s2[17:0];
			r.t2 = t2[17:0];
		end
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		st_pair_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_st.size() == 0) begin
				$display("%t: unexpected result beat cnt=%0d", $realtime, solution_count);
				errors++;
			end else begin
				e = pending_st.pop_front();
				if (solution_count !== e.cnt) begin
					$display("%t: count exp %0d got %0d", $realtime, e.cnt, solution_count);
					errors++;
				end
				if (first_s !== e.s1) begin
					$display("%t: first_s exp %0d got %0d", $realtime, e.s1, first_s);
					errors++;
				end
				if (first_t !== e.t1) begin
					$display("%t: first_t exp %0d got %0d", $realtime, e.t1, first_t);
					errors++;
				end
				if (second_s !== e.s2) begin
					$display("%t: second_s exp %0d got %0d", $realtime, e.s2, second_s);
					errors++;
				end
				if (second_t !== e.t2) begin
					$display("%t: second_t exp %0d got %0d", $realtime, e.t2, second_t);
					errors++;
				end
			end
		end
	end

	// receiver back-pressure in bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 3);
		end else
			out_stall <= 1'b0;
	end

	task automatic drain();
		while (pending_st.size() != 0) @(posedge clk);
	endtask

	task automatic load_corners(longint v[8]);
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data <= v[i][31:0];
			corner_q8[i] = longint'(signed'(v[i][31:0]));
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic send_point(bit [31:0] x, bit [31:0] y, bit zero_known);
		st_pair_t e;
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		point_x <= x;
		point_y <= y;
		if (zero_known) e = '{default: '0};
		else            e = solve_point(x, y);
		do @(posedge clk); while (in_stall);
		pending_st = {pending_st, e};
	endtask

	task automatic add_row(int ph, bit [31:0] x, bit [31:0] y, bit zero_known);
		point_row_t r;
		r.ph = ph;
		r.x = x;
		r.y = y;
		r.zero_known = zero_known;
		rows = {rows, r};
	endtask

	// point on the quad at parameters (s,t) given in real, plus a little jitter
	function automatic bit [31:0] warp(real s, real t, int ax);
		real v;
		v = (1.0 - t) * ((1.0 - s) * corner_q8[ax] + s * corner_q8[2 + ax])
			+ t * ((1.0 - s) * corner_q8[4 + ax] + s * corner_q8[6 + ax]);
		return 32'($rtoi(v) + $urandom_range(0, 4) - 2);
	endfunction

	task automatic pick_corners(int kind);
		longint v[8];
		longint bx, by, w, h;
		bx = $urandom_range(0, 1 << 22) - (1 << 21);
		by = $urandom_range(0, 1 << 22) - (1 << 21);
		w = $urandom_range(64, 1 << 18);
		h = $urandom_range(64, 1 << 18);
		if ($urandom_range(0, 1)) w = -w;
		v[REG_BL_X] = bx;
		v[REG_BL_Y] = by;
		v[REG_BR_X] = bx + w;
		v[REG_BR_Y] = by + $urandom_range(0, w > 0 ? w / 4 : -w / 4);
		v[REG_TL_X] = bx + $urandom_range(0, h / 4);
		v[REG_TL_Y] = by + h;
		case (kind)
			0: begin
				v[REG_TR_X] = v[REG_BR_X] + $urandom_range(0, h / 2) - h / 4;
				v[REG_TR_Y] = v[REG_TL_Y] + $urandom_range(0, h / 2) - h / 4;
			end
			1: begin // parallelogram: quadratic term vanishes
				v[REG_TR_X] = v[REG_BR_X] + v[REG_TL_X] - bx;
				v[REG_TR_Y] = v[REG_BR_Y] + v[REG_TL_Y] - by;
			end
			2: begin // saturating spans
				for (int i = 0; i < 8; i++)
					v[i] = ($urandom_range(0, 1)) ? 32'sh7fffffff : -32'sh80000000;
			end
			default: begin
				for (int i = 0; i < 8; i++) v[i] = longint'(signed'(32'($urandom())));
			end
		endcase
		load_corners(v);
	endtask

	initial begin
		longint sq[8];
		int ph;
		real s, t;
		bit [31:0] x, y;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		point_x = '0;
		point_y = '0;
		for (int i = 0; i < 8; i++) corner_q8[i] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero corners after reset: degenerate quad, nothing found
		add_row(0, 32'h0, 32'h0, 1'b1);
		add_row(0, 32'h8000_0000, 32'h8000_0000, 1'b1);
		add_row(0, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
		add_row(0, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
		add_row(0, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
		add_row(0, 32'hffff_ffff, 32'h0000_0001, 1'b1);
		// 65536-unit square: corners, centre, edges, just outside the edges, far outside
		add_row(1, 32'h0, 32'h0, 1'b0);
		add_row(1, 32'h1_0000, 32'h0, 1'b0);
		add_row(1, 32'h0, 32'h1_0000, 1'b0);
		add_row(1, 32'h1_0000, 32'h1_0000, 1'b0);
		add_row(1, 32'h8000, 32'h8000, 1'b0);
		add_row(1, 32'h8000, 32'h0, 1'b0);
		add_row(1, 32'hffff_ffff, 32'h8000, 1'b0);
		add_row(1, 32'h1_0001, 32'h8000, 1'b0);
		add_row(1, 32'h8000, 32'h2_0000, 1'b0);
		add_row(1, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
		ph = 0;
		foreach (rows[i]) begin
			if (rows[i].ph != ph) begin
				in_valid <= 1'b0;
				drain();
				sq = '{0, 0, 32'h1_0000, 0, 0, 32'h1_0000, 32'h1_0000, 32'h1_0000};
				load_corners(sq);
				ph = rows[i].ph;
			end
			send_point(rows[i].x, rows[i].y, rows[i].zero_known);
		end

		for (int p = 0; p < 8; p++) begin
			in_valid <= 1'b0;
			drain();
			pick_corners(p % 4);
			if (p == 7) calm = 1'b1;
			for (int n = 0; n < 150; n++) begin
				if (p == 2 && n == 75) begin
					// hold off until the pipeline is empty
					in_valid <= 1'b0;
					drain();
				end
				if ($urandom_range(0, 3) != 0) begin
					s = ($urandom_range(0, 1400) - 200) / 1000.0;
					t = ($urandom_range(0, 1400) - 200) / 1000.0;
					x = warp(s, t, 0);
					y = warp(s, t, 1);
				end else begin
					x = $urandom();
					y = $urandom();
				end
				send_point(x, y, 1'b0);
			end
		end
		in_valid <= 1'b0;
		drain();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
